// ===== hw/rtl/rtc_dtw_pkg.sv =====
// Package for the date/time wrap and clock register encoder.
// Holds field widths, range limits and the small binary-to-BCD and
// days-in-month helpers. No dependencies.
package rtc_dtw_pkg;

    // Stream widths: input item is 56 bits, result item is 45 bits padded to 48.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    // Normalized year fits in 12 bits (1970..2500).
    localparam int YEAR_W = 12;

    localparam logic [15:0] YEAR_MIN = 16'd1970;
    localparam logic [15:0] YEAR_MAX = 16'd2500;

    // Century years in range that are not leap years.
    localparam logic [YEAR_W-1:0] CENT_2100 = 12'd2100;
    localparam logic [YEAR_W-1:0] CENT_2200 = 12'd2200;
    localparam logic [YEAR_W-1:0] CENT_2300 = 12'd2300;
    localparam logic [YEAR_W-1:0] CENT_2500 = 12'd2500;

    localparam logic signed [7:0] MONTH_LO  = 8'sd1;
    localparam logic signed [7:0] MONTH_HI  = 8'sd12;
    localparam logic signed [7:0] DAY_LO    = 8'sd1;
    localparam logic signed [7:0] HOUR_HI   = 8'sd23;
    localparam logic signed [7:0] MINSEC_HI = 8'sd59;

    // Month codes that need their own day count.
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    // Binary 0..59 to packed BCD. Tens digit is (v * 13) >> 7, exact over 0..59.
    function automatic logic [6:0] to_bcd(input logic [5:0] v);
        logic [9:0] prod;
        logic [2:0] tens;
        logic [5:0] tens_x10;
        logic [3:0] units;
        prod     = {4'd0, v} * 10'd13;
        tens     = prod[9:7];
        tens_x10 = {tens, 3'd0} - {2'd0, tens, 1'b0} + {1'b0, tens, 2'd0};
        units    = 4'(v - tens_x10);
        return {tens, units};
    endfunction

    // Days in a month (1..12) with a leap-year flag.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        unique case (month)
            MON_FEB:                            days = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: days = 5'd30;
            default:                            days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

// ===== hw/rtl/rtc_date_time_wrap_bcd_encode.sv =====
// Top level of the date/time wrap and clock register encoder.
// A three-stage pipeline with a stream handshake on each side; uses rtc_dtw_pkg.
//
// The block takes one date and time per item, wraps each field once to the
// opposite end of its range (year 1970..2500, month 1..12, day 1..days of the
// month under the Gregorian leap rule, hour 0..23, minute and second 0..59) and
// returns the clock register bytes, date and time in BCD and the year in binary.
// It accepts one item per clock cycle while the output does not stall; each
// result passes through three register stages (field wrap, day wrap with time
// BCD, date BCD and packing), the first of which loads at the accepting edge.
// A stall on the output holds the pipeline, and bubbles in it are filled while
// a result waits. There is no configuration and no state beyond the pipeline.
module rtc_date_time_wrap_bcd_encode
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // From bit 0: year_in[15:0], month_in[7:0], day_in[7:0], hour_in[7:0],
    // minute_in[7:0], second_in[7:0].
    input  logic [rtc_dtw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // From bit 0: seconds_byte[6:0], minutes_byte[6:0], hours_byte[5:0],
    // year_date_byte[7:0], month_byte[4:0], year_high_byte[3:0],
    // year_low_byte[7:0], then three zero bits.
    output logic [rtc_dtw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import rtc_dtw_pkg::*;

    // Input field unpacking.
    logic [15:0]       year_in;
    logic signed [7:0] month_in;
    logic signed [7:0] day_in;
    logic signed [7:0] hour_in;
    logic signed [7:0] minute_in;
    logic signed [7:0] second_in;

    assign year_in   = s_axis_tdata[15:0];
    assign month_in  = s_axis_tdata[23:16];
    assign day_in    = s_axis_tdata[31:24];
    assign hour_in   = s_axis_tdata[39:32];
    assign minute_in = s_axis_tdata[47:40];
    assign second_in = s_axis_tdata[55:48];

    // Stage valid bits and load enables.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_load, s2_load, s3_load;

    assign s3_load       = !s3_valid_reg || m_axis_tready;
    assign s2_load       = !s2_valid_reg || s3_load;
    assign s1_load       = !s1_valid_reg || s2_load;
    assign s_axis_tready = s1_load;
    assign m_axis_tvalid = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_load)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: wrap year, month and time fields; find the leap flag.
    logic [YEAR_W-1:0]  s1_year_next, s1_year_reg;
    logic [3:0]         s1_month_next, s1_month_reg;
    logic signed [7:0]  s1_day_reg;
    logic [4:0]         s1_hour_next, s1_hour_reg;
    logic [5:0]         s1_minute_next, s1_minute_reg;
    logic [5:0]         s1_second_next, s1_second_reg;
    logic               s1_leap_next, s1_leap_reg;
    logic [15:0]        year_wrapped;

    always_comb
    begin
        if (year_in > YEAR_MAX)
        begin
            year_wrapped = YEAR_MIN;
        end
        else if (year_in < YEAR_MIN)
        begin
            year_wrapped = YEAR_MAX;
        end
        else
        begin
            year_wrapped = year_in;
        end
        s1_year_next = year_wrapped[YEAR_W-1:0];

        // Only 2100, 2200, 2300 and 2500 break the four-year rule in range.
        s1_leap_next = (s1_year_next[1:0] == 2'd0)
                    && (s1_year_next != CENT_2100) && (s1_year_next != CENT_2200)
                    && (s1_year_next != CENT_2300) && (s1_year_next != CENT_2500);

        if (month_in > MONTH_HI)
        begin
            s1_month_next = MONTH_LO[3:0];
        end
        else if (month_in < MONTH_LO)
        begin
            s1_month_next = MONTH_HI[3:0];
        end
        else
        begin
            s1_month_next = month_in[3:0];
        end

        if (hour_in > HOUR_HI)
        begin
            s1_hour_next = 5'd0;
        end
        else if (hour_in < 8'sd0)
        begin
            s1_hour_next = HOUR_HI[4:0];
        end
        else
        begin
            s1_hour_next = hour_in[4:0];
        end

        if (minute_in > MINSEC_HI)
        begin
            s1_minute_next = 6'd0;
        end
        else if (minute_in < 8'sd0)
        begin
            s1_minute_next = MINSEC_HI[5:0];
        end
        else
        begin
            s1_minute_next = minute_in[5:0];
        end

        if (second_in > MINSEC_HI)
        begin
            s1_second_next = 6'd0;
        end
        else if (second_in < 8'sd0)
        begin
            s1_second_next = MINSEC_HI[5:0];
        end
        else
        begin
            s1_second_next = second_in[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_year_reg   <= s1_year_next;
            s1_leap_reg   <= s1_leap_next;
            s1_month_reg  <= s1_month_next;
            s1_day_reg    <= day_in;
            s1_hour_reg   <= s1_hour_next;
            s1_minute_reg <= s1_minute_next;
            s1_second_reg <= s1_second_next;
        end
    end

    // Stage 2: wrap the day against the month length; time fields to BCD.
    logic [4:0]         month_len;
    logic signed [7:0]  month_len_s;
    logic [4:0]         s2_day_next, s2_day_reg;
    logic [YEAR_W-1:0]  s2_year_reg;
    logic [3:0]         s2_month_reg;
    logic [6:0]         s2_sec_bcd_reg, s2_min_bcd_reg, s2_hour_bcd_next;
    logic [5:0]         s2_hour_bcd_reg;

    always_comb
    begin
        month_len   = month_days(s1_month_reg, s1_leap_reg);
        month_len_s = $signed({3'd0, month_len});
        if (s1_day_reg > month_len_s)
        begin
            s2_day_next = DAY_LO[4:0];
        end
        else if (s1_day_reg < DAY_LO)
        begin
            s2_day_next = month_len;
        end
        else
        begin
            s2_day_next = s1_day_reg[4:0];
        end
        s2_hour_bcd_next = to_bcd({1'b0, s1_hour_reg});
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_year_reg     <= s1_year_reg;
            s2_month_reg    <= s1_month_reg;
            s2_day_reg      <= s2_day_next;
            s2_sec_bcd_reg  <= to_bcd(s1_second_reg);
            s2_min_bcd_reg  <= to_bcd(s1_minute_reg);
            s2_hour_bcd_reg <= s2_hour_bcd_next[5:0];
        end
    end

    // Stage 3: date and month to BCD and pack the register bytes.
    logic [6:0]              day_bcd, month_bcd;
    logic [OUT_TDATA_W-1:0]  s3_tdata_next, s3_tdata_reg;

    always_comb
    begin
        day_bcd       = to_bcd({1'b0, s2_day_reg});
        month_bcd     = to_bcd({2'b00, s2_month_reg});
        s3_tdata_next = {3'b000,
                         s2_year_reg[7:2], 2'b00,
                         s2_year_reg[11:8],
                         month_bcd[4:0],
                         s2_year_reg[1:0], day_bcd[5:0],
                         s2_hour_bcd_reg,
                         s2_min_bcd_reg,
                         s2_sec_bcd_reg};
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_tdata_reg <= s3_tdata_next;
        end
    end

    assign m_axis_tdata = s3_tdata_reg;

endmodule

// ===== bench/tb_rtc_date_time_wrap_bcd_encode.sv =====
// Self-checking testbench for the date/time wrap and clock register encoder.
// Drives date/time items on the input stream and checks every result item
// against an in-bench predictor; depends on rtc_dtw_pkg and the top level.
module tb_rtc_date_time_wrap_bcd_encode;

    import rtc_dtw_pkg::IN_TDATA_W;
    import rtc_dtw_pkg::OUT_TDATA_W;

    localparam int RESET_CYCLES = 10;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 270;
    localparam int HOLD_CYCLES  = 200;
    localparam int BURST_ITEMS  = 40;

    // Input item fields, first field in the lowest bits.
    typedef struct packed {
        logic [7:0]  second_in;
        logic [7:0]  minute_in;
        logic [7:0]  hour_in;
        logic [7:0]  day_in;
        logic [7:0]  month_in;
        logic [15:0] year_in;
    } dt_in_t;

    // Clock register bytes, first field in the lowest bits.
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] year_low_byte;
        logic [3:0] year_high_byte;
        logic [4:0] month_byte;
        logic [7:0] year_date_byte;
        logic [5:0] hours_byte;
        logic [6:0] minutes_byte;
        logic [6:0] seconds_byte;
    } rtc_regs_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    rtc_regs_t expected_regs[$];
    rtc_regs_t want_regs;
    rtc_regs_t got_regs;
    int        error_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_request = 0;
    int        hold_left = 0;

    rtc_date_time_wrap_bcd_encode u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock with a period of 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // A value outside its range moves once to the opposite end of the range.
    function automatic int wrap_field(input int v, input int lo, input int hi);
        if (v > hi)
            v = lo;
        if (v < lo)
            v = hi;
        return v;
    endfunction

    function automatic int bcd_of(input int v);
        return ((v / 10) << 4) | (v % 10);
    endfunction

    // Predict the clock register bytes for one date/time item.
    function automatic rtc_regs_t encode_date_time(input dt_in_t d);
        int        yr;
        int        mon;
        int        dy;
        int        hr;
        int        mn;
        int        sc;
        int        dim;
        bit        leap;
        rtc_regs_t r;
        yr = int'(d.year_in);
        if (yr > int'(rtc_dtw_pkg::YEAR_MAX))
            yr = int'(rtc_dtw_pkg::YEAR_MIN);
        if (yr < int'(rtc_dtw_pkg::YEAR_MIN))
            yr = int'(rtc_dtw_pkg::YEAR_MAX);
        mon = wrap_field(int'($signed(d.month_in)), int'(rtc_dtw_pkg::MONTH_LO),
                         int'(rtc_dtw_pkg::MONTH_HI));

        // Gregorian leap rule, with the wrapped month and year.
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        if (mon == int'(rtc_dtw_pkg::MON_FEB))
            dim = leap ? 29 : 28;
        else if (mon == int'(rtc_dtw_pkg::MON_APR) || mon == int'(rtc_dtw_pkg::MON_JUN) ||
                 mon == int'(rtc_dtw_pkg::MON_SEP) || mon == int'(rtc_dtw_pkg::MON_NOV))
            dim = 30;
        else
            dim = 31;

        dy = wrap_field(int'($signed(d.day_in)), int'(rtc_dtw_pkg::DAY_LO), dim);
        hr = wrap_field(int'($signed(d.hour_in)), 0, int'(rtc_dtw_pkg::HOUR_HI));
        mn = wrap_field(int'($signed(d.minute_in)), 0, int'(rtc_dtw_pkg::MINSEC_HI));
        sc = wrap_field(int'($signed(d.second_in)), 0, int'(rtc_dtw_pkg::MINSEC_HI));

        r.pad            = '0;
        r.seconds_byte   = 7'(bcd_of(sc));
        r.minutes_byte   = 7'(bcd_of(mn));
        r.hours_byte     = 6'(bcd_of(hr));
        r.year_date_byte = {2'(yr), 6'(bcd_of(dy))};
        r.month_byte     = 5'(bcd_of(mon));
        r.year_high_byte = 4'(yr >> 8);
        r.year_low_byte  = 8'(yr) & 8'hFC;
        return r;
    endfunction

    function automatic dt_in_t make_item(input int yr, input int mo, input int dy,
                                         input int hr, input int mi, input int sc);
        dt_in_t d;
        d.year_in   = 16'(yr);
        d.month_in  = 8'(mo);
        d.day_in    = 8'(dy);
        d.hour_in   = 8'(hr);
        d.minute_in = 8'(mi);
        d.second_in = 8'(sc);
        return d;
    endfunction

    // Mostly values near the ranges, sometimes raw bits over the whole field.
    function automatic dt_in_t random_item();
        dt_in_t d;
        if ($urandom_range(3) == 0)
        begin
            d = IN_TDATA_W'({$urandom(), $urandom()});
        end
        else
        begin
            if ($urandom_range(9) == 0)
                d.year_in = 16'($urandom());
            else
                d.year_in = 16'($urandom_range(2505, 1965));
            d.month_in  = 8'($signed($urandom_range(15)) - 1);
            d.day_in    = 8'($signed($urandom_range(34)) - 1);
            d.hour_in   = 8'($signed($urandom_range(27)) - 2);
            d.minute_in = 8'($signed($urandom_range(63)) - 2);
            d.second_in = 8'($signed($urandom_range(63)) - 2);
        end
        return d;
    endfunction

    // Offer one item after a random idle gap and record its expected result.
    task automatic send_item(input dt_in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_regs.push_back(encode_date_time(item));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Year limits, far out-of-range years and the leap rule at the edges.
    task automatic test_year_limits();
        send_item(make_item(0, 1, 1, 0, 0, 0));
        send_item(make_item(1969, 2, 29, 0, 0, 0));
        send_item(make_item(1970, 1, 1, 0, 0, 0));
        send_item(make_item(2500, 12, 31, 23, 59, 59));
        send_item(make_item(2501, 2, 29, 0, 0, 0));
        send_item(make_item(65535, 6, 15, 12, 30, 30));
        send_item(make_item(2000, 2, 29, 1, 2, 3));
        send_item(make_item(2100, 2, 29, 1, 2, 3));
        send_item(make_item(2024, 2, 0, 1, 2, 3));
        send_item(make_item(2023, 2, 0, 1, 2, 3));
    endtask

    // Month wrap and day counts; the day range follows the wrapped month.
    task automatic test_month_days();
        send_item(make_item(2024, -128, 32, 0, 0, 0));
        send_item(make_item(2024, 0, 32, 0, 0, 0));
        send_item(make_item(2024, 13, 0, 0, 0, 0));
        send_item(make_item(2024, 127, 127, 0, 0, 0));
        send_item(make_item(2024, 4, 31, 0, 0, 0));
        send_item(make_item(2024, 11, 0, 0, 0, 0));
        send_item(make_item(2024, 2, 30, 0, 0, 0));
        send_item(make_item(2024, 1, -128, 0, 0, 0));
    endtask

    // Time fields at both ends and far outside.
    task automatic test_time_limits();
        send_item(make_item(2010, 5, 5, -1, -1, -1));
        send_item(make_item(2010, 5, 5, 24, 60, 60));
        send_item(make_item(2010, 5, 5, -128, -128, -128));
        send_item(make_item(2010, 5, 5, 127, 127, 127));
        send_item(make_item(2010, 5, 5, 23, 59, 0));
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_item(random_item());
    endtask

    // The receiver holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        repeat (BURST_ITEMS)
            send_item(random_item());
    endtask

    // Receiver ready: random stalls, plus a long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare every accepted result item with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_regs.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, got %0h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want_regs = expected_regs.pop_front();
                got_regs  = m_axis_tdata;
                check_field("seconds_byte", want_regs.seconds_byte, got_regs.seconds_byte);
                check_field("minutes_byte", want_regs.minutes_byte, got_regs.minutes_byte);
                check_field("hours_byte", want_regs.hours_byte, got_regs.hours_byte);
                check_field("year_date_byte", want_regs.year_date_byte,
                            got_regs.year_date_byte);
                check_field("month_byte", want_regs.month_byte, got_regs.month_byte);
                check_field("year_high_byte", want_regs.year_high_byte,
                            got_regs.year_high_byte);
                check_field("year_low_byte", want_regs.year_low_byte,
                            got_regs.year_low_byte);
                check_field("padding", want_regs.pad, got_regs.pad);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(negedge clk);

        test_year_limits();
        test_month_days();
        test_time_limits();
        test_random_phase(0, 0, PHASE_ITEMS);
        test_random_phase(46, 0, PHASE_ITEMS);
        test_backpressure();
        test_random_phase(0, 46, PHASE_ITEMS);
        test_random_phase(12, 12, PHASE_ITEMS);

        // Stop offering items and let the pipeline drain.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_regs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
